@@ hdl/pvh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pvh_pkg
// Shared constants, codes and beat layouts of the phase velocity histogram.
// ----------------------------------------------------------------------------
package pvh_pkg;

  // sizes
  localparam int HIST_BINS_DEF = 64;
  localparam int NUM_CLASSES   = 4;
  localparam int NUM_AXES      = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int OUT_DEPTH     = 4;

  // field widths
  localparam int VEL_W       = 32;
  localparam int FRAC_W      = 17;
  localparam int SPD_W       = 32;
  localparam int PROD_W      = 64;
  localparam int CNT_W       = 32;
  localparam int CLASS_W     = 2;
  localparam int RBIN_W      = 6;
  localparam int MODE_W      = 2;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int S_TDATA_W   = 144;
  localparam int S_TUSER_W   = 3;
  localparam int M_TDATA_W   = 128;

  // fraction of a whole cell, Q1.16
  localparam int FRAC_ONE = 65536;

  // item kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_ACCUM = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } pvh_mode_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_EPS     = 8'd0,
    REG_SCALE_X = 8'd1,
    REG_SCALE_Y = 8'd2,
    REG_SCALE_Z = 8'd3
  } pvh_reg_t;

  // classified item handed from front to back
  typedef struct packed {
    pvh_mode_t              op;
    logic [NUM_CLASSES-1:0] member;
    logic [SPD_W-1:0]       spd_z;
    logic [SPD_W-1:0]       spd_y;
    logic [SPD_W-1:0]       spd_x;
    logic [CLASS_W-1:0]     read_class;
    logic [RBIN_W-1:0]      read_bin;
  } pvh_job_t;

  // read result, bin count in the lowest bits
  typedef struct packed {
    logic [SPD_W-1:0] peak_z;
    logic [SPD_W-1:0] peak_y;
    logic [SPD_W-1:0] peak_x;
    logic [CNT_W-1:0] bin_count;
  } pvh_result_t;

endpackage
`default_nettype wire

@@ hdl/pvh_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pvh_ram
// Generic single write port RAM with a registered read port.
// ----------------------------------------------------------------------------
module pvh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read returning the old contents on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ hdl/pvh_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pvh_fifo
// Small register based queue with valid/ready on both sides.
// ----------------------------------------------------------------------------
module pvh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/pvh_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pvh_front
// Takes input beats, holds the configuration, scales velocities, finds the
// bin and class membership of each cell and hands classified jobs onward.
// ----------------------------------------------------------------------------
module pvh_front #(
  parameter int HIST_BINS = pvh_pkg::HIST_BINS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pvh_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [pvh_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input beats
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [pvh_pkg::S_TDATA_W-1:0]       s_tdata,
  input  wire logic [pvh_pkg::S_TUSER_W-1:0]       s_tuser,
  // classified jobs
  output logic                                     job_valid,
  input  wire logic                                job_ready,
  output pvh_pkg::pvh_job_t                        job,
  output logic [$clog2(HIST_BINS)-1:0]             job_bin
);

  localparam int BIN_W  = $clog2(HIST_BINS);
  localparam int VEL_W  = pvh_pkg::VEL_W;
  localparam int FRAC_W = pvh_pkg::FRAC_W;
  localparam int SPD_W  = pvh_pkg::SPD_W;
  localparam int PROD_W = pvh_pkg::PROD_W;
  localparam int REST_W = FRAC_W + 2;
  localparam int NAX    = pvh_pkg::NUM_AXES;

  // configuration registers
  logic [FRAC_W-1:0] eps_threshold;
  logic [SPD_W-1:0]  scale [NAX];

  // stage registers
  logic                           s1_valid;
  logic [pvh_pkg::MODE_W-1:0]     s1_mode;
  logic                           s1_ghost;
  logic [VEL_W-1:0]               s1_vel [NAX];
  logic [FRAC_W-1:0]              s1_frac_first;
  logic [FRAC_W-1:0]              s1_frac_second;
  logic [pvh_pkg::CLASS_W-1:0]    s1_read_class;
  logic [pvh_pkg::RBIN_W-1:0]     s1_read_bin;

  logic                           s2_valid;
  pvh_pkg::pvh_job_t              s2_job;
  logic [VEL_W-1:0]               s2_abs [NAX];

  logic                           s3_valid;
  pvh_pkg::pvh_job_t              s3_job;
  logic [PROD_W-1:0]              s3_prod [NAX];

  logic                           s4_valid;
  pvh_pkg::pvh_job_t              s4_job;
  logic [PROD_W-1:0]              s4_pmax01;
  logic [PROD_W-1:0]              s4_prod_z;

  logic                           s5_valid;
  pvh_pkg::pvh_job_t              s5_job;
  logic [PROD_W-1:0]              s5_pmax;

  logic                           s6_valid;
  pvh_pkg::pvh_job_t              s6_job;
  logic [BIN_W-1:0]               s6_bin;

  // combinational results per stage
  logic                           advance;
  logic                           s2_keep;
  logic [VEL_W-1:0]               abs_next [NAX];
  logic [REST_W-1:0]              rest;
  pvh_pkg::pvh_job_t              job_next;
  logic [PROD_W-1:0]              prod_next [NAX];
  logic [SPD_W-1:0]               spd_next [NAX];
  pvh_pkg::pvh_job_t              job4_next;
  logic [PROD_W-1:0]              pmax01_next;
  logic [PROD_W-1:0]              pmax_next;
  logic [SPD_W:0]                 ceil_bin;
  logic [BIN_W-1:0]               bin_next;

  assign cfg_ready = 1'b1;
  assign advance   = !s6_valid || job_ready;
  assign s_tready  = advance;
  assign job_valid = s6_valid;
  assign job       = s6_job;
  assign job_bin   = s6_bin;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      eps_threshold <= '0;
      for (int a = 0; a < NAX; a++) begin
        scale[a] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pvh_pkg::REG_EPS:     eps_threshold <= cfg_data[FRAC_W-1:0];
        pvh_pkg::REG_SCALE_X: scale[0] <= cfg_data[SPD_W-1:0];
        pvh_pkg::REG_SCALE_Y: scale[1] <= cfg_data[SPD_W-1:0];
        pvh_pkg::REG_SCALE_Z: scale[2] <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits move with the whole pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid && s2_keep;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
    end
  end

  // stage 1: capture the beat
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mode        <= s_tuser[1:0];
      s1_ghost       <= s_tuser[2];
      s1_vel[0]      <= s_tdata[31:0];
      s1_vel[1]      <= s_tdata[63:32];
      s1_vel[2]      <= s_tdata[95:64];
      s1_frac_first  <= s_tdata[112:96];
      s1_frac_second <= s_tdata[129:113];
      s1_read_class  <= s_tdata[131:130];
      s1_read_bin    <= s_tdata[137:132];
    end
  end

  // stage 2: kind, magnitudes and class membership
  always_comb begin
    s2_keep = ((s1_mode == pvh_pkg::MODE_ACCUM) && !s1_ghost) ||
              (s1_mode == pvh_pkg::MODE_READ) ||
              (s1_mode == pvh_pkg::MODE_CLEAR);
    for (int a = 0; a < NAX; a++) begin
      abs_next[a] = s1_vel[a][VEL_W-1] ? (~s1_vel[a] + 1'b1) : s1_vel[a];
    end
    // unoccupied fraction, may go negative
    rest = REST_W'(pvh_pkg::FRAC_ONE) - {2'b00, s1_frac_first} - {2'b00, s1_frac_second};
    job_next            = '0;
    job_next.op         = pvh_pkg::pvh_mode_t'(s1_mode);
    job_next.member[0]  = 1'b1;
    job_next.member[1]  = (s1_frac_first >= eps_threshold);
    job_next.member[2]  = (s1_frac_second >= eps_threshold);
    job_next.member[3]  = !rest[REST_W-1] && (rest[REST_W-2:0] >= {1'b0, eps_threshold});
    job_next.read_class = s1_read_class;
    job_next.read_bin   = s1_read_bin;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_job <= job_next;
      for (int a = 0; a < NAX; a++) begin
        s2_abs[a] <= abs_next[a];
      end
    end
  end

  // stage 3: scaled speeds, exact Q32.32 products
  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      prod_next[a] = PROD_W'(s2_abs[a]) * PROD_W'(scale[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_job <= s2_job;
      for (int a = 0; a < NAX; a++) begin
        s3_prod[a] <= prod_next[a];
      end
    end
  end

  // stage 4: truncate to Q16.16 with saturation, first half of the maximum
  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      spd_next[a] = (|s3_prod[a][PROD_W-1:SPD_W+16]) ? '1 : s3_prod[a][SPD_W+15:16];
    end
    job4_next       = s3_job;
    job4_next.spd_x = spd_next[0];
    job4_next.spd_y = spd_next[1];
    job4_next.spd_z = spd_next[2];
    pmax01_next = (s3_prod[0] > s3_prod[1]) ? s3_prod[0] : s3_prod[1];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_job    <= job4_next;
      s4_pmax01 <= pmax01_next;
      s4_prod_z <= s3_prod[2];
    end
  end

  // stage 5: largest product
  assign pmax_next = (s4_pmax01 > s4_prod_z) ? s4_pmax01 : s4_prod_z;

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_job  <= s4_job;
      s5_pmax <= pmax_next;
    end
  end

  // stage 6: ceiling of the largest product, clamped to the last bin
  always_comb begin
    ceil_bin = {1'b0, s5_pmax[PROD_W-1:32]} + (SPD_W + 1)'(|s5_pmax[31:0]);
    if (ceil_bin > (SPD_W + 1)'(HIST_BINS - 1)) begin
      bin_next = BIN_W'(HIST_BINS - 1);
    end else begin
      bin_next = ceil_bin[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s6_job <= s5_job;
      s6_bin <= bin_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/pvh_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pvh_back
// Carries out jobs: read-modify-write of the class histograms, running
// maxima, reads and the clearing sweep.
// ----------------------------------------------------------------------------
module pvh_back #(
  parameter int HIST_BINS = pvh_pkg::HIST_BINS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // classified jobs
  input  wire logic                          job_valid,
  output logic                               job_ready,
  input  wire pvh_pkg::pvh_job_t             job,
  input  wire logic [$clog2(HIST_BINS)-1:0]  job_bin,
  // read results
  output logic                               res_valid,
  output pvh_pkg::pvh_result_t               res,
  input  wire logic                          res_taken
);

  localparam int BIN_W  = $clog2(HIST_BINS);
  localparam int NCL    = pvh_pkg::NUM_CLASSES;
  localparam int NAX    = pvh_pkg::NUM_AXES;
  localparam int CNT_W  = pvh_pkg::CNT_W;
  localparam int SPD_W  = pvh_pkg::SPD_W;
  localparam int CRED_W = $clog2(pvh_pkg::OUT_DEPTH + 1);

  // read stage
  logic                 b1_valid;
  pvh_pkg::pvh_job_t    b1_job;
  logic [BIN_W-1:0]     b1_addr;
  logic                 b1_in_range;

  // clearing sweep
  logic                 clearing;
  logic [BIN_W-1:0]     clr_addr;

  // reads issued and not yet taken from the output queue
  logic [CRED_W-1:0]    outstanding;

  // memory ports
  logic [BIN_W-1:0]     rd_addr;
  logic [CNT_W-1:0]     rd_data [NCL];
  logic [NCL-1:0]       wr_en;
  logic [BIN_W-1:0]     wr_addr;
  logic [CNT_W-1:0]     wr_data [NCL];

  // last write, for a read issued on the same edge
  logic [NCL-1:0]       byp_en;
  logic [BIN_W-1:0]     byp_addr;
  logic [CNT_W-1:0]     byp_data [NCL];

  logic [SPD_W-1:0]     peak [NCL][NAX];

  logic                 pop_ok;
  logic                 pop;
  logic                 b1_accum;
  logic                 b1_clear;
  logic [31:0]          rb_wide;
  logic                 rb_in_range;
  logic [CNT_W-1:0]     cur [NCL];
  logic [CNT_W-1:0]     incr [NCL];
  logic [SPD_W-1:0]     b1_spd [NAX];

  assign b1_accum = b1_valid && (b1_job.op == pvh_pkg::MODE_ACCUM);
  assign b1_clear = b1_valid && (b1_job.op == pvh_pkg::MODE_CLEAR);

  // issue: hold off during a sweep, behind a clear, or without result space
  always_comb begin
    pop_ok = !clearing && !b1_clear &&
             ((job.op != pvh_pkg::MODE_READ) ||
              (outstanding < CRED_W'(pvh_pkg::OUT_DEPTH)));
    pop    = job_valid && pop_ok;
  end
  assign job_ready = pop_ok;

  // read address: bin of the cell, or the requested bin
  always_comb begin
    rb_wide     = 32'(job.read_bin);
    rb_in_range = (rb_wide < 32'(HIST_BINS));
    rd_addr     = (job.op == pvh_pkg::MODE_READ) ? rb_wide[BIN_W-1:0] : job_bin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    b1_job      <= job;
    b1_addr     <= rd_addr;
    b1_in_range <= rb_in_range;
  end

  // one histogram memory per class
  for (genvar c = 0; c < NCL; c++) begin : g_class
    pvh_ram #(
      .WIDTH (CNT_W),
      .DEPTH (HIST_BINS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en[c]),
      .wr_addr (wr_addr),
      .wr_data (wr_data[c]),
      .rd_addr (rd_addr),
      .rd_data (rd_data[c])
    );
  end

  // current count with bypass, saturating increment
  always_comb begin
    for (int c = 0; c < NCL; c++) begin
      cur[c]  = (byp_en[c] && (byp_addr == b1_addr)) ? byp_data[c] : rd_data[c];
      incr[c] = (&cur[c]) ? cur[c] : cur[c] + 1'b1;
    end
  end

  // memory writes: sweep or update
  always_comb begin
    if (clearing) begin
      wr_addr = clr_addr;
      for (int c = 0; c < NCL; c++) begin
        wr_en[c]   = 1'b1;
        wr_data[c] = '0;
      end
    end else begin
      wr_addr = b1_addr;
      for (int c = 0; c < NCL; c++) begin
        wr_en[c]   = b1_accum && b1_job.member[c];
        wr_data[c] = incr[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_en <= '0;
    end else begin
      byp_en <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    byp_addr <= wr_addr;
    for (int c = 0; c < NCL; c++) begin
      byp_data[c] <= wr_data[c];
    end
  end

  // clearing sweep after reset and on a clear beat
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (b1_clear) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == BIN_W'(HIST_BINS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // running maxima per class and axis
  assign b1_spd[0] = b1_job.spd_x;
  assign b1_spd[1] = b1_job.spd_y;
  assign b1_spd[2] = b1_job.spd_z;

  always_ff @(posedge clk) begin
    if (rst || b1_clear) begin
      for (int c = 0; c < NCL; c++) begin
        for (int a = 0; a < NAX; a++) begin
          peak[c][a] <= '0;
        end
      end
    end else if (b1_accum) begin
      for (int c = 0; c < NCL; c++) begin
        for (int a = 0; a < NAX; a++) begin
          if (b1_job.member[c] && (b1_spd[a] > peak[c][a])) begin
            peak[c][a] <= b1_spd[a];
          end
        end
      end
    end
  end

  // read result
  always_comb begin
    res_valid     = b1_valid && (b1_job.op == pvh_pkg::MODE_READ);
    res.bin_count = b1_in_range ? cur[b1_job.read_class] : '0;
    res.peak_x    = peak[b1_job.read_class][0];
    res.peak_y    = peak[b1_job.read_class][1];
    res.peak_z    = peak[b1_job.read_class][2];
  end

  // result space bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding
                     + CRED_W'(pop && (job.op == pvh_pkg::MODE_READ))
                     - CRED_W'(res_taken);
    end
  end

endmodule
`default_nettype wire

@@ hdl/phase_velocity_histogram_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phase_velocity_histogram_core
// Velocity histogram with per-class running maxima over streamed grid cells.
// ----------------------------------------------------------------------------
// Usage
//   cfg channel: write eps_threshold (index 0) and scale_x/y/z (1..3) while
//   the block is idle; every write beat is taken at once.
//   s channel: one cell or command per beat, mode and ghost in tuser.
//   Accumulate and clear beats give no output; a read beat gives one m beat.
// Throughput: one beat per cycle for accumulate and read when nothing stalls,
//   set by the single read-modify-write pass per class histogram memory.
// Order: a read result passes front stages 1 to 6, the job queue, the back
//   read stage and the result queue; an accumulate is visible to any later read.
// Clear: zeroes the maxima at once and sweeps the histograms bin by bin, during
//   which beats are still taken until the queues fill.
// Reset: clears the configuration and runs the same sweep.
// Stall: a held m_tready stops reads at the result queue; accumulate beats
//   keep flowing until a read waits for room, then s_tready drops.
// ----------------------------------------------------------------------------
module phase_velocity_histogram_core #(
  parameter int HIST_BINS = pvh_pkg::HIST_BINS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pvh_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [pvh_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // vel_x, vel_y, vel_z, frac_first, frac_second, read_class, read_bin, zero pad
  input  wire logic [pvh_pkg::S_TDATA_W-1:0]    s_tdata,
  // mode, ghost
  input  wire logic [pvh_pkg::S_TUSER_W-1:0]    s_tuser,
  // result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // bin_count, peak_x, peak_y, peak_z
  output logic [pvh_pkg::M_TDATA_W-1:0]         m_tdata
);

  localparam int BIN_W   = $clog2(HIST_BINS);
  localparam int JOB_W   = $bits(pvh_pkg::pvh_job_t);
  localparam int QUEUE_W = JOB_W + BIN_W;
  localparam int RES_W   = $bits(pvh_pkg::pvh_result_t);

  logic                   front_valid;
  logic                   front_ready;
  pvh_pkg::pvh_job_t      front_job;
  logic [BIN_W-1:0]       front_bin;
  logic [QUEUE_W-1:0]     q_in_data;
  logic                   q_out_valid;
  logic                   q_out_ready;
  logic [QUEUE_W-1:0]     q_out_data;
  pvh_pkg::pvh_job_t      back_job;
  logic [BIN_W-1:0]       back_bin;
  logic                   res_valid;
  pvh_pkg::pvh_result_t   res;
  logic                   res_taken;

  // front: configuration, scaling and classification
  pvh_front #(
    .HIST_BINS (HIST_BINS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job),
    .job_bin   (front_bin)
  );

  // job queue between front and back
  assign q_in_data = {front_bin, front_job};

  pvh_fifo #(
    .WIDTH (QUEUE_W),
    .DEPTH (pvh_pkg::QUEUE_DEPTH)
  ) u_job_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (q_in_data),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_data  (q_out_data)
  );

  assign back_job = q_out_data[JOB_W-1:0];
  assign back_bin = q_out_data[JOB_W +: BIN_W];

  // back: histogram and maxima
  pvh_back #(
    .HIST_BINS (HIST_BINS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_out_valid),
    .job_ready (q_out_ready),
    .job       (back_job),
    .job_bin   (back_bin),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken)
  );

  // result queue, room reserved by the back before a read is issued
  assign res_taken = m_tvalid && m_tready;

  pvh_fifo #(
    .WIDTH (RES_W),
    .DEPTH (pvh_pkg::OUT_DEPTH)
  ) u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

@@ verif/phase_velocity_histogram_core_test.sv @@
// ----------------------------------------------------------------------------
// phase_velocity_histogram_core_test
// Self-checking bench for the phase velocity histogram core. Grid cells, reads,
// clears and unused commands are streamed in with random gaps while the result
// side stalls at random. A scoreboard keeps its own histograms and per-class
// maxima, predicts every read answer and compares it field by field.
// ----------------------------------------------------------------------------
module phase_velocity_histogram_core_test;

  localparam int VEL_W       = pvh_pkg::VEL_W;
  localparam int FRAC_W      = pvh_pkg::FRAC_W;
  localparam int SPD_W       = pvh_pkg::SPD_W;
  localparam int PROD_W      = pvh_pkg::PROD_W;
  localparam int CNT_W       = pvh_pkg::CNT_W;
  localparam int CLASS_W     = pvh_pkg::CLASS_W;
  localparam int RBIN_W      = pvh_pkg::RBIN_W;
  localparam int MODE_W      = pvh_pkg::MODE_W;
  localparam int CFG_INDEX_W = pvh_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = pvh_pkg::CFG_DATA_W;
  localparam int S_TDATA_W   = pvh_pkg::S_TDATA_W;
  localparam int S_TUSER_W   = pvh_pkg::S_TUSER_W;
  localparam int M_TDATA_W   = pvh_pkg::M_TDATA_W;
  localparam int NUM_CLASSES = pvh_pkg::NUM_CLASSES;
  localparam int NUM_AXES    = pvh_pkg::NUM_AXES;
  localparam int FRAC_ONE    = pvh_pkg::FRAC_ONE;

  localparam int BINS = pvh_pkg::HIST_BINS_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = BINS + 40;
  localparam int NUM_PHASES = 8;
  localparam int CELLS_PER_PHASE = 112;

  // input beat layout
  localparam int F1_LSB = 3 * VEL_W;
  localparam int F2_LSB = F1_LSB + FRAC_W;
  localparam int RC_LSB = F2_LSB + FRAC_W;
  localparam int RB_LSB = RC_LSB + CLASS_W;
  localparam int GHOST_BIT = MODE_W;

  // histogram and maxima model with the queue of predicted read answers
  class velocity_histogram_scoreboard;
    logic [FRAC_W-1:0]     eps;
    logic [SPD_W-1:0]      scale [NUM_AXES];
    logic [CNT_W-1:0]      counts [NUM_CLASSES][BINS];
    logic [SPD_W-1:0]      peaks [NUM_CLASSES][NUM_AXES];
    pvh_pkg::pvh_result_t  pending_reads [$];
    int                    errors;

    function new();
      eps = '0;
      foreach (scale[a]) scale[a] = '0;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (counts[c, b]) counts[c][b] = '0;
      foreach (peaks[c, a]) peaks[c][a] = '0;
    endfunction

    function void set_reg(pvh_pkg::pvh_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        pvh_pkg::REG_EPS:     eps = val[FRAC_W-1:0];
        pvh_pkg::REG_SCALE_X: scale[0] = val;
        pvh_pkg::REG_SCALE_Y: scale[1] = val;
        pvh_pkg::REG_SCALE_Z: scale[2] = val;
        default: ;
      endcase
    endfunction

    // scale, bin and classify one cell, then update every class it belongs to
    function void add_cell(logic [S_TDATA_W-1:0] d);
      logic [VEL_W-1:0]       v;
      logic [VEL_W-1:0]       mag;
      logic [PROD_W-1:0]      prod;
      logic [PROD_W-1:0]      top;
      logic [PROD_W:0]        rounded;
      logic [SPD_W-1:0]       spd [NUM_AXES];
      logic [NUM_CLASSES-1:0] member;
      int                     bin;
      int                     f1;
      int                     f2;
      int                     rest;
      top = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        v = d[a*VEL_W +: VEL_W];
        mag = v[VEL_W-1] ? (~v + 1'b1) : v;
        prod = {32'b0, mag} * {32'b0, scale[a]};
        spd[a] = (prod[63:48] != 0) ? {SPD_W{1'b1}} : prod[47:16];
        if (prod > top) top = prod;
      end
      // ceiling of the largest exact product, clamped to the last bin
      rounded = ({1'b0, top} + 65'hFFFF_FFFF) >> 32;
      bin = (rounded > BINS - 1) ? BINS - 1 : int'(rounded);
      f1 = int'(d[F1_LSB +: FRAC_W]);
      f2 = int'(d[F2_LSB +: FRAC_W]);
      rest = FRAC_ONE - f1 - f2;
      member[0] = 1'b1;
      member[1] = f1 >= int'(eps);
      member[2] = f2 >= int'(eps);
      member[3] = rest >= 0 && rest >= int'(eps);
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (member[c]) begin
          if (counts[c][bin] != {CNT_W{1'b1}}) counts[c][bin]++;
          for (int a = 0; a < NUM_AXES; a++)
            if (spd[a] > peaks[c][a]) peaks[c][a] = spd[a];
        end
      end
    endfunction

    function void note_input(logic [S_TDATA_W-1:0] d, logic [S_TUSER_W-1:0] u);
      logic [CLASS_W-1:0]    cls;
      logic [RBIN_W-1:0]     rb;
      pvh_pkg::pvh_result_t  r;
      cls = d[RC_LSB +: CLASS_W];
      rb = d[RB_LSB +: RBIN_W];
      case (u[MODE_W-1:0])
        pvh_pkg::MODE_ACCUM: if (!u[GHOST_BIT]) add_cell(d);
        pvh_pkg::MODE_READ: begin
          r.bin_count = (rb < BINS) ? counts[cls][rb] : '0;
          r.peak_x = peaks[cls][0];
          r.peak_y = peaks[cls][1];
          r.peak_z = peaks[cls][2];
          pending_reads.push_back(r);
        end
        pvh_pkg::MODE_CLEAR: wipe();
        default: ;
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    task check_result(logic [M_TDATA_W-1:0] d);
      pvh_pkg::pvh_result_t got;
      pvh_pkg::pvh_result_t want;
      got = d;
      if (pending_reads.size() == 0) begin
        report("result with no read waiting", got.bin_count, '0);
        return;
      end
      want = pending_reads.pop_front();
      if (got.bin_count != want.bin_count) report("bin_count", got.bin_count, want.bin_count);
      if (got.peak_x != want.peak_x) report("peak_x", got.peak_x, want.peak_x);
      if (got.peak_y != want.peak_y) report("peak_y", got.peak_y, want.peak_y);
      if (got.peak_z != want.peak_z) report("peak_z", got.peak_z, want.peak_z);
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic [S_TUSER_W-1:0]   s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  velocity_histogram_scoreboard book;

  phase_velocity_histogram_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // beats taken on either stream go to the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) book.note_input(s_tdata, s_tuser);
      if (m_tvalid && m_tready) book.check_result(m_tdata);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one beat on the input stream, valid held high afterwards
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic ghost_cell,
                           input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy,
                           input logic [VEL_W-1:0] vz, input logic [FRAC_W-1:0] f1,
                           input logic [FRAC_W-1:0] f2, input logic [CLASS_W-1:0] rc,
                           input logic [RBIN_W-1:0] rb);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, rb, rc, f2, f1, vz, vy, vx};
    s_tuser <= {ghost_cell, mode};
    do @(posedge clk); while (!s_tready);
  endtask

  // sender stops until all reads are answered and the sweep has had time to end
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (book.pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input pvh_pkg::pvh_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(idx, val);
  endtask

  task automatic configure(input logic [FRAC_W-1:0] eps, input logic [SPD_W-1:0] sx,
                           input logic [SPD_W-1:0] sy, input logic [SPD_W-1:0] sz);
    wait_drained();
    write_reg(pvh_pkg::REG_EPS, CFG_DATA_W'(eps));
    write_reg(pvh_pkg::REG_SCALE_X, sx);
    write_reg(pvh_pkg::REG_SCALE_Y, sy);
    write_reg(pvh_pkg::REG_SCALE_Z, sz);
    cfg_valid <= 1'b0;
  endtask

  // mostly small speeds so the bins spread, some full range and extremes
  function automatic logic [VEL_W-1:0] rand_vel();
    logic [VEL_W-1:0] mag;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        mag = $urandom_range(0, 70 << 16);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] rand_frac();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return FRAC_W'(FRAC_ONE);
      2: return book.eps;
      default: return FRAC_W'($urandom_range(0, FRAC_ONE));
    endcase
  endfunction

  function automatic logic [SPD_W-1:0] rand_scale();
    return $urandom_range(32'h4000, 32'h4_0000);
  endfunction

  task automatic send_random_item();
    int                pick;
    logic [MODE_W-1:0] mode;
    logic [RBIN_W-1:0] rb;
    pick = $urandom_range(0, 99);
    if (pick < 62) mode = pvh_pkg::MODE_ACCUM;
    else if (pick < 94) mode = pvh_pkg::MODE_READ;
    else if (pick < 96) mode = pvh_pkg::MODE_CLEAR;
    else mode = MODE_UNUSED;
    rb = $urandom_range(0, 1) ? RBIN_W'($urandom_range(0, 10)) : RBIN_W'($urandom);
    send_item(mode, $urandom_range(0, 9) == 0, rand_vel(), rand_vel(), rand_vel(),
              rand_frac(), rand_frac(), CLASS_W'($urandom), rb);
  endtask

  initial begin
    book = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed cells: speed extremes, exact and just-over bin edges, each class
    configure(17'd16384, 32'h1_0000, 32'h1_0000, 32'h1_0000);
    send_item(pvh_pkg::MODE_ACCUM, 1'b0, 32'd0, 32'd0, 32'd0, 17'd65536, 17'd0, 2'd0, 6'd0);
    send_item(pvh_pkg::MODE_ACCUM, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
              17'd0, 17'd65536, 2'd0, 6'd0);
    send_item(pvh_pkg::MODE_ACCUM, 1'b0, 32'h3_0000, 32'hFFFB_0001, 32'd2,
              17'd0, 17'd0, 2'd0, 6'd0);
    // ghost cell leaves everything alone
    send_item(pvh_pkg::MODE_ACCUM, 1'b1, 32'h5_0000, 32'h7FFF_FFFF, 32'd0,
              17'd65536, 17'd65536, 2'd0, 6'd0);
    // fractions summing past one, no empty share
    send_item(pvh_pkg::MODE_ACCUM, 1'b0, 32'h1_0000, 32'd0, 32'd0,
              17'd65536, 17'd65536, 2'd0, 6'd0);
    send_item(pvh_pkg::MODE_ACCUM, 1'b0, 32'd0, 32'h1_0001, 32'd0,
              17'd40000, 17'd30000, 2'd0, 6'd0);
    // unused command is dropped
    send_item(MODE_UNUSED, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
              17'd65536, 17'd65536, 2'd3, 6'd63);
    send_item(pvh_pkg::MODE_READ, 1'b0, '1, '1, '1, '1, '1, 2'd0, 6'd0);
    send_item(pvh_pkg::MODE_READ, 1'b0, '0, '0, '0, '0, '0, 2'd1, 6'd1);
    send_item(pvh_pkg::MODE_READ, 1'b0, '0, '0, '0, '0, '0, 2'd2, 6'd63);
    send_item(pvh_pkg::MODE_READ, 1'b0, '0, '0, '0, '0, '0, 2'd3, 6'd5);
    send_item(pvh_pkg::MODE_READ, 1'b0, '0, '0, '0, '0, '0, 2'd0, 6'd63);
    send_item(pvh_pkg::MODE_READ, 1'b0, '0, '0, '0, '0, '0, 2'd0, 6'd2);
    send_item(pvh_pkg::MODE_READ, 1'b0, '0, '0, '0, '0, '0, 2'd1, 6'd0);
    send_item(pvh_pkg::MODE_READ, 1'b0, '0, '0, '0, '0, '0, 2'd3, 6'd63);
    // clear, then reads see empty state
    send_item(pvh_pkg::MODE_CLEAR, 1'b0, '1, '1, '1, '1, '1, 2'd3, 6'd63);
    send_item(pvh_pkg::MODE_READ, 1'b0, '0, '0, '0, '0, '0, 2'd0, 6'd63);
    send_item(pvh_pkg::MODE_READ, 1'b0, '0, '0, '0, '0, '0, 2'd2, 6'd1);
    send_item(pvh_pkg::MODE_ACCUM, 1'b0, 32'h1_8000, 32'd0, 32'd0, 17'd0, 17'd0, 2'd0, 6'd0);
    send_item(pvh_pkg::MODE_READ, 1'b0, '0, '0, '0, '0, '0, 2'd3, 6'd2);

    // random phases, each with its own register setting and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: configure(17'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: configure(17'd65536, 32'd0, 32'd0, 32'd0);
        2: configure(17'd32768, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        3: configure(17'd1, 32'hFFFF_FFFF, 32'd0, 32'h8000);
        default: configure(FRAC_W'($urandom_range(0, FRAC_ONE)),
                           rand_scale(), rand_scale(), rand_scale());
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      repeat (CELLS_PER_PHASE) send_random_item();
    end

    wait_drained();
    if (book.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
